FILE: rtl/msp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI output stream parser package
// Shared constants, result codes, record types and the status length lookup.
// ----------------------------------------------------------------------------
package msp_pkg;

    localparam int SYSEX_MAX   = 1024;
    localparam int SX_LEN_W    = $clog2(SYSEX_MAX);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [SX_LEN_W-1:0] SX_LIMIT = SX_LEN_W'(SYSEX_MAX - 1);

    localparam logic [7:0] SYSEX_START  = 8'hF0;
    localparam logic [7:0] SYSEX_END    = 8'hF7;
    localparam logic [7:0] REALTIME_MIN = 8'hF8;

    localparam logic [1:0] KIND_SHORT   = 2'd0;
    localparam logic [1:0] KIND_SX_DATA = 2'd1;
    localparam logic [1:0] KIND_SX_END  = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] status_byte;
        logic [6:0] first_data;
        logic [6:0] second_data;
        logic [1:0] data_length;
        logic [7:0] sysex_byte;
        logic [9:0] sysex_count;
        logic       truncated;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [7:0]          running_status;
        logic [6:0]          held_first;
        logic [6:0]          held_second;
        logic [1:0]          expected_length;
        logic [1:0]          data_position;
        logic                ignore_data;
        logic                in_sysex;
        logic [SX_LEN_W-1:0] sysex_length;
    } parse_state_t;

    // Number of data bytes that follow a status byte.
    function automatic logic [1:0] status_length(input logic [7:0] s);
        logic [1:0] len;
        unique case (s[7:4])
            4'hC, 4'hD: len = 2'd1;
            4'hF: begin
                unique case (s[3:0])
                    4'h0, 4'h1, 4'h3: len = 2'd1;
                    4'h2:             len = 2'd2;
                    default:          len = 2'd0;
                endcase
            end
            default: len = 2'd2;
        endcase
        return len;
    endfunction

endpackage

FILE: rtl/msp_parse_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI parser core
// Holds the running status state and decodes one byte per fired cycle into
// up to two result words.
// ----------------------------------------------------------------------------
module msp_parse_core import msp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       fire,
    input  logic [7:0] in_byte,
    output logic [1:0] push_n,
    output result_t    res0,
    output result_t    res1
);

    parse_state_t st_reg;
    parse_state_t st_next;
    logic         end_hit;
    logic         main_hit;
    logic         main_sx;
    logic [1:0]   pos_inc;
    result_t      end_res;
    result_t      main_res;

    assign pos_inc = st_reg.data_position + 2'd1;

    always_comb begin
        st_next  = st_reg;
        end_hit  = 1'b0;
        main_hit = 1'b0;
        main_sx  = 1'b0;
        if (in_byte[7]) begin
            // A non real-time status closes an open sysex first.
            end_hit = st_reg.in_sysex && (in_byte < REALTIME_MIN);
            if (end_hit) begin
                st_next.in_sysex    = 1'b0;
                st_next.ignore_data = 1'b1;
            end
            if (!(end_hit && (in_byte == SYSEX_END))) begin
                st_next.running_status  = in_byte;
                st_next.expected_length = status_length(in_byte);
                st_next.data_position   = 2'd0;
                st_next.ignore_data     = 1'b0;
                if (in_byte == SYSEX_START) begin
                    st_next.in_sysex     = 1'b1;
                    st_next.sysex_length = SX_LEN_W'(1);
                    main_hit             = 1'b1;
                    main_sx              = 1'b1;
                end else if (status_length(in_byte) == 2'd0) begin
                    main_hit = 1'b1;
                end
            end
        end else if (st_reg.in_sysex) begin
            if (st_reg.sysex_length < SX_LIMIT) begin
                st_next.sysex_length = st_reg.sysex_length + SX_LEN_W'(1);
                main_hit             = 1'b1;
                main_sx              = 1'b1;
            end
        end else if (!st_reg.ignore_data) begin
            if (pos_inc == 2'd1) begin
                st_next.held_first = in_byte[6:0];
            end else begin
                st_next.held_second = in_byte[6:0];
            end
            if (pos_inc >= st_reg.expected_length) begin
                st_next.data_position = 2'd0;
                main_hit              = 1'b1;
            end else begin
                st_next.data_position = pos_inc;
            end
        end
    end

    always_comb begin
        end_res            = '0;
        end_res.kind       = KIND_SX_END;
        end_res.sysex_byte = SYSEX_END;
        if (st_reg.sysex_length < SX_LIMIT) begin
            end_res.sysex_count = 10'(st_reg.sysex_length + SX_LEN_W'(1));
            end_res.truncated   = 1'b0;
        end else begin
            end_res.sysex_count = 10'(SX_LIMIT);
            end_res.truncated   = 1'b1;
        end
        end_res.last = !main_hit;

        main_res = '0;
        if (main_sx) begin
            main_res.kind       = KIND_SX_DATA;
            main_res.sysex_byte = in_byte;
        end else begin
            main_res.kind        = KIND_SHORT;
            main_res.status_byte = st_next.running_status;
            main_res.first_data  = st_next.held_first;
            main_res.second_data = st_next.held_second;
            main_res.data_length = st_next.expected_length;
        end
        main_res.last = 1'b1;
    end

    assign res0   = end_hit ? end_res : main_res;
    assign res1   = main_res;
    assign push_n = fire ? ({1'b0, end_hit} + {1'b0, main_hit}) : 2'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            // Data bytes are dropped until the first status byte.
            st_reg <= '{running_status: 8'h00, held_first: 7'h00, held_second: 7'h00,
                        expected_length: 2'd0, data_position: 2'd0, ignore_data: 1'b1,
                        in_sysex: 1'b0, sysex_length: SX_LEN_W'(0)};
        end else if (fire) begin
            st_reg <= st_next;
        end
    end

endmodule

FILE: rtl/msp_result_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI parser result queue
// Small queue taking up to two result words per cycle and handing one word
// per cycle to the output channel while it is ready.
// ----------------------------------------------------------------------------
module msp_result_queue import msp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [1:0] push_n,
    input  result_t    res0,
    input  result_t    res1,
    output logic       room2,
    output logic       out_valid,
    input  logic       out_ready,
    output result_t    out_word
);

    result_t           mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              pop;

    assign out_valid = (count_reg != '0);
    assign out_word  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    // Room for two words regardless of what leaves this cycle.
    assign room2     = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));

    assign count_next = count_reg + QCNT_W'(push_n) - QCNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            mem_reg[wr_ptr_reg] <= res0;
        end
        if (push_n == 2'd2) begin
            mem_reg[wr_ptr_reg + QPTR_W'(1)] <= res1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + QPTR_W'(push_n);
            rd_ptr_reg <= rd_ptr_reg + QPTR_W'(pop);
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/midi_output_stream_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI output stream parser
// Running status parser for a MIDI output byte stream, with sysex pass-through.
//
//   Channel  Direction  Ports                         Word
//   s_       in         s_valid s_ready s_midi_byte   one MIDI byte
//   m_       out        m_valid m_ready m_kind ...    one parsed result
//
// A byte is registered, decoded from that register once the queue has room
// for two words, and its zero, one or two results enter a four-word queue
// that drives the output channel. One byte is taken every cycle while the
// queue holds at most two words, so a sink that takes a word per cycle never
// stalls the input while each byte yields at most one word. A run of bytes
// that each yield two words outruns such a sink, and the input then waits
// until the queue is back to two words. Reset is synchronous and leaves the
// parser dropping data bytes until the first status byte.
// ----------------------------------------------------------------------------
module midi_output_stream_parser import msp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_midi_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_kind,
    output logic [7:0] m_status_byte,
    output logic [6:0] m_first_data,
    output logic [6:0] m_second_data,
    output logic [1:0] m_data_length,
    output logic [7:0] m_sysex_byte,
    output logic [9:0] m_sysex_count,
    output logic       m_truncated,
    output logic       m_last
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       fire;
    logic       room2;
    logic [1:0] push_n;
    result_t    res0;
    result_t    res1;
    result_t    out_word;

    assign fire    = in_valid_reg && room2;
    assign s_ready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_midi_byte;
        end
    end

    msp_parse_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .in_byte (in_byte_reg),
        .push_n  (push_n),
        .res0    (res0),
        .res1    (res1)
    );

    msp_result_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_n    (push_n),
        .res0      (res0),
        .res1      (res1),
        .room2     (room2),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_word  (out_word)
    );

    assign m_kind        = out_word.kind;
    assign m_status_byte = out_word.status_byte;
    assign m_first_data  = out_word.first_data;
    assign m_second_data = out_word.second_data;
    assign m_data_length = out_word.data_length;
    assign m_sysex_byte  = out_word.sysex_byte;
    assign m_sysex_count = out_word.sysex_count;
    assign m_truncated   = out_word.truncated;
    assign m_last        = out_word.last;

endmodule
